// ----- hw/rtl/dss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dense slot sparse set block.
// ---------------------------------------------------------------------------
package dss_pkg;

  // Default sizes
  localparam int ENTITY_BITS_DEF = 10;
  localparam int MAX_SLOTS_DEF   = 256;

  // Fixed field widths on the ports
  localparam int CMD_W      = 2;
  localparam int ENT_FW     = 10;
  localparam int STS_W      = 2;
  localparam int SLOT_FW    = 8;
  localparam int OFF_W      = 14;
  localparam int SRC_FW     = 8;
  localparam int CNT_FW     = 9;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // Component size register
  localparam int WORDS_W   = 7;
  localparam int WORDS_MAX = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_PRESENT   = 2'd2,
    STS_FULL      = 2'd3
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_OWN,
    S_MOVE,
    S_CLR
  } state_t;

endpackage : dss_pkg
`default_nettype wire

// ----- hw/rtl/dss_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dss_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued. Contents start at zero.
// ---------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Power-up contents
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mem[i] = '0;
    end
  end

  // Write port
  always @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : dss_ram
`default_nettype wire

// ----- hw/rtl/dense_slot_sparse_set_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dense_slot_sparse_set_top
// Packed slot store for entity components (sparse set with swap-remove).
// ---------------------------------------------------------------------------
// Sequence: get, add and remove read the entity map RAM, then the slot owner
// RAM (a moving remove also reads the last slot's owner); clear reads none.
// One item in flight; a new item is taken only once the last one finishes,
// and a finish waits while an untaken result is held. Results sit in an
// output register while the next item starts. Reset zeroes the live count
// and sets component_words to 1; no clearing pass, presence is derived from
// map and owner agreeing.
module dense_slot_sparse_set_top
  import dss_pkg::*;
#(
  parameter int ENTITY_BITS = ENTITY_BITS_DEF,
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration: component_words
  input  wire logic                  cfg_we,
  input  wire logic [WORDS_W-1:0]    cfg_wdata,
  // Command stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] entity_id
  input  wire logic [CMD_W-1:0]      in_tuser,   // [1:0] command
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] slot, [21:8] word_offset,
                                                 // [22] move_needed,
                                                 // [30:23] move_source,
                                                 // [39:31] live_count
  output logic [STS_W-1:0]           out_tuser   // [1:0] status
);

  localparam int ENT_W  = ENTITY_BITS;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int PROD_W = SLOT_W + WORDS_W;

  // Control and payload registers
  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  logic [ENT_W-1:0]   ent_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [CNT_W-1:0]   count_r, cnt_nxt;
  logic [WORDS_W-1:0] words_r;

  logic               out_valid_r;
  sts_t               out_sts_r;
  logic [SLOT_FW-1:0] out_slot_r;
  logic [OFF_W-1:0]   out_off_r;
  logic               out_mv_r;
  logic [SRC_FW-1:0]  out_src_r;
  logic [CNT_FW-1:0]  out_cnt_r;

  // RAM ports
  logic               map_we, map_re;
  logic [ENT_W-1:0]   map_waddr, map_raddr;
  logic [SLOT_W-1:0]  map_wdata, map_rdata;
  logic               own_we, own_re;
  logic [SLOT_W-1:0]  own_waddr, own_raddr;
  logic [ENT_W-1:0]   own_wdata, own_rdata;

  // Datapath
  cmd_t               cmd_in;
  logic [ENT_W-1:0]   ent_in;
  logic [CNT_W-1:0]   last;
  logic               hit, is_last, full, out_free, fin;
  sts_t               res_sts;
  logic [SLOT_W-1:0]  res_slot, res_src;
  logic               res_has, res_mv;
  logic [WORDS_W-1:0] words_eff;
  logic [PROD_W-1:0]  prod;

  assign cmd_in = cmd_t'(in_tuser);
  assign ent_in = ENT_W'(in_tdata[ENT_FW-1:0]);

  // Entity -> slot map and slot -> owner list
  dss_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (2 ** ENT_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  dss_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SLOTS)
  ) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .re    (own_re),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  // Lookup terms: present when the slot is live and its owner points back
  assign last     = count_r - CNT_W'(1);
  assign hit      = (CNT_W'(slot_r) < count_r) && (own_rdata == ent_r);
  assign is_last  = (slot_r == SLOT_W'(last));
  assign full     = (count_r >= CNT_W'(MAX_SLOTS));
  assign out_free = !out_valid_r || out_tready;

  // Clamp component size to 1..64
  always_comb begin
    if (words_r == '0) begin
      words_eff = WORDS_W'(1);
    end else if (words_r > WORDS_W'(WORDS_MAX)) begin
      words_eff = WORDS_W'(WORDS_MAX);
    end else begin
      words_eff = words_r;
    end
  end

  assign prod = PROD_W'(res_slot) * PROD_W'(words_eff);

  // Next state, RAM control and result selection
  always_comb begin
    state_nxt = state_r;
    map_re    = 1'b0;
    map_raddr = ent_in;
    map_we    = 1'b0;
    map_waddr = ent_r;
    map_wdata = SLOT_W'(count_r);
    own_re    = 1'b0;
    own_raddr = map_rdata;
    own_we    = 1'b0;
    own_waddr = SLOT_W'(count_r);
    own_wdata = ent_r;
    fin       = 1'b0;
    res_sts   = STS_OK;
    res_slot  = slot_r;
    res_has   = 1'b0;
    res_mv    = 1'b0;
    res_src   = '0;
    cnt_nxt   = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (cmd_in == CMD_CLEAR) begin
            state_nxt = S_CLR;
          end else begin
            map_re    = 1'b1;
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        own_re    = 1'b1;
        state_nxt = S_OWN;
      end
      S_OWN: begin
        if (cmd_r == CMD_REMOVE && hit && !is_last) begin
          // fetch the owner of the last slot, it moves into the hole
          own_re    = 1'b1;
          own_raddr = SLOT_W'(last);
          state_nxt = S_MOVE;
        end else if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r)
            CMD_GET: begin
              res_sts = hit ? STS_OK : STS_NOT_FOUND;
              res_has = hit;
            end
            CMD_ADD: begin
              if (hit) begin
                res_sts = STS_PRESENT;
                res_has = 1'b1;
              end else if (full) begin
                res_sts = STS_FULL;
              end else begin
                res_slot = SLOT_W'(count_r);
                res_has  = 1'b1;
                own_we   = 1'b1;
                map_we   = 1'b1;
                cnt_nxt  = count_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              // removal of the last slot, or a miss
              if (hit) begin
                res_has = 1'b1;
                cnt_nxt = last;
              end else begin
                res_sts = STS_NOT_FOUND;
              end
            end
            default: begin
              res_sts = STS_OK;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
          res_has   = 1'b1;
          res_mv    = 1'b1;
          res_src   = SLOT_W'(last);
          own_we    = 1'b1;
          own_waddr = slot_r;
          own_wdata = own_rdata;
          map_we    = 1'b1;
          map_waddr = own_rdata;
          map_wdata = slot_r;
          cnt_nxt   = last;
        end
      end
      S_CLR: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      words_r     <= WORDS_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= cnt_nxt;
      if (cfg_we) begin
        words_r <= cfg_wdata;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and lookup payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= cmd_in;
      ent_r <= ent_in;
    end
    if (state_r == S_MAP) begin
      slot_r <= map_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fin) begin
      out_sts_r  <= res_sts;
      out_slot_r <= res_has ? SLOT_FW'(res_slot) : '0;
      out_off_r  <= res_has ? OFF_W'(prod) : '0;
      out_mv_r   <= res_mv;
      out_src_r  <= SRC_FW'(res_src);
      out_cnt_r  <= CNT_FW'(cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = {out_cnt_r, out_src_r, out_mv_r, out_off_r, out_slot_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SLOTS))
    else $error("live count above slot capacity");

  a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (own_we || map_we) |-> fin)
    else $error("table write outside a finishing step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && cmd_r == CMD_ADD && res_sts == STS_OK && state_r == S_OWN)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("add did not grow the live count");

endmodule : dense_slot_sparse_set_top
`default_nettype wire
